>>> sv/mpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multilevel priority task queue package
// Shared types, field widths and parameter defaults for the queue block.
// ----------------------------------------------------------------------------
package mpq_pkg;

  // Parameter defaults
  localparam int unsigned LEVELS_DEF      = 4;
  localparam int unsigned LEVEL_DEPTH_DEF = 64;
  localparam int unsigned HANDLE_BITS_DEF = 16;

  // Fixed field widths of the channel words
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;

  // Action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_RD,
    S_RM_SCAN,
    S_RM_CHECK,
    S_DONE
  } state_e;

  // Input word
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [HANDLE_W-1:0] handle;
    logic [LEVEL_W-1:0]  level;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [HANDLE_W-1:0] popped_handle;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  total_count;
  } out_word_t;

endpackage
`default_nettype wire

>>> sv/mpq_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Entry store
// Single-port handle memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module mpq_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write, and read the addressed entry into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> sv/mpq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Queue sequencer
// Holds per-level head and fill, drives the entry store through one shared
// slot adder, and walks the levels to compact them on a remove.
// ----------------------------------------------------------------------------
module mpq_ctrl #(
  parameter int unsigned LEVELS      = 4,
  parameter int unsigned LEVEL_DEPTH = 64,
  parameter int unsigned HANDLE_BITS = 16,
  parameter int unsigned LVW         = 2,
  parameter int unsigned PW          = 6
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input word
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire mpq_pkg::in_word_t      in_word_i,
  // result handoff
  output logic                        res_valid_o,
  input  wire logic                   res_take_i,
  output mpq_pkg::out_word_t          res_word_o,
  // entry store
  output logic                        mem_we_o,
  output logic [LVW+PW-1:0]           mem_addr_o,
  output logic [HANDLE_BITS-1:0]      mem_wdata_o,
  input  wire logic [HANDLE_BITS-1:0] mem_rdata_i
);

  import mpq_pkg::*;

  localparam int unsigned FW = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned TW = $clog2(LEVELS * LEVEL_DEPTH + 1);
  localparam logic [FW-1:0] DEPTH_F = FW'(LEVEL_DEPTH);
  localparam logic [PW:0] DEPTH_S = (PW+1)'(LEVEL_DEPTH);
  localparam logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_W'(LEVELS - 1);
  localparam logic [LVW-1:0] LAST_LV = LVW'(LEVELS - 1);

  state_e                 state_q, state_d;
  logic [PW-1:0]          head_q [LEVELS];
  logic [PW-1:0]          head_d [LEVELS];
  logic [FW-1:0]          fill_q [LEVELS];
  logic [FW-1:0]          fill_d [LEVELS];
  logic [TW-1:0]          total_q, total_d;
  logic [ACTION_W-1:0]    act_q, act_d;
  logic [HANDLE_BITS-1:0] hdl_q, hdl_d;
  logic [LVW-1:0]         lv_q, lv_d;
  logic [FW-1:0]          rcnt_q, rcnt_d;
  logic [FW-1:0]          wcnt_q, wcnt_d;
  logic [TW-1:0]          sum_q, sum_d;
  out_word_t              res_q, res_d;

  // shared slot adder: (base + off) mod LEVEL_DEPTH
  logic [PW-1:0]  slot_base;
  logic [FW-1:0]  slot_off;
  logic [PW:0]    slot_sum;
  logic [PW-1:0]  slot_res;
  logic [LVW-1:0] lv_sel;

  // input conversion and lowest non-empty level
  logic [HANDLE_BITS-1:0] hdl_in;
  logic [LVW-1:0]         lv_in;
  logic [LVW-1:0]         first_lv;
  logic                   any_held;
  logic [HANDLE_W-1:0]    rd_out;

  assign slot_sum = {1'b0, slot_base} + (PW+1)'(slot_off);
  assign slot_res = (slot_sum >= DEPTH_S) ? PW'(slot_sum - DEPTH_S) : PW'(slot_sum);

  // Handle zero-extend/truncate into storage width, clamp the push level
  always_comb begin
    hdl_in = '0;
    for (int i = 0; i < int'(HANDLE_BITS); i++) begin
      if (i < int'(HANDLE_W)) begin
        hdl_in[i] = in_word_i.handle[i];
      end
    end
    if (in_word_i.level > LAST_LEVEL) begin
      lv_in = LAST_LV;
    end else begin
      lv_in = LVW'(in_word_i.level);
    end
  end

  // Stored handle to output width
  always_comb begin
    rd_out = '0;
    for (int i = 0; i < int'(HANDLE_W); i++) begin
      if (i < int'(HANDLE_BITS)) begin
        rd_out[i] = mem_rdata_i[i];
      end
    end
  end

  // Priority pick of the most urgent level holding entries
  always_comb begin
    first_lv = '0;
    any_held = 1'b0;
    for (int i = int'(LEVELS) - 1; i >= 0; i--) begin
      if (fill_q[i] != '0) begin
        first_lv = LVW'(i);
        any_held = 1'b1;
      end
    end
  end

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      for (int i = 0; i < int'(LEVELS); i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      for (int i = 0; i < int'(LEVELS); i++) begin
        head_q[i] <= head_d[i];
        fill_q[i] <= fill_d[i];
      end
    end
  end

  // Working registers, no reset
  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    hdl_q  <= hdl_d;
    lv_q   <= lv_d;
    rcnt_q <= rcnt_d;
    wcnt_q <= wcnt_d;
    sum_q  <= sum_d;
    res_q  <= res_d;
  end

  // Next state, store access and result
  always_comb begin
    logic          finish;
    logic [TW-1:0] new_total;
    logic [STATUS_W-1:0] st_code;
    logic [HANDLE_W-1:0] got;

    finish    = 1'b0;
    new_total = total_q;
    st_code   = ST_OK;
    got       = '0;

    state_d = state_q;
    total_d = total_q;
    for (int i = 0; i < int'(LEVELS); i++) begin
      head_d[i] = head_q[i];
      fill_d[i] = fill_q[i];
    end
    act_d  = act_q;
    hdl_d  = hdl_q;
    lv_d   = lv_q;
    rcnt_d = rcnt_q;
    wcnt_d = wcnt_q;
    sum_d  = sum_q;
    res_d  = res_q;

    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_wdata_o = hdl_q;
    lv_sel      = lv_q;
    slot_off    = '0;

    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          act_d   = in_word_i.action;
          hdl_d   = hdl_in;
          lv_d    = lv_in;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        case (act_q)
          ACT_PUSH: begin
            slot_off = fill_q[lv_q];
            if (fill_q[lv_q] == DEPTH_F) begin
              st_code = ST_FULL;
            end else begin
              mem_we_o         = 1'b1;
              fill_d[lv_q]     = fill_q[lv_q] + 1'b1;
              new_total        = total_q + 1'b1;
              total_d          = new_total;
            end
            finish = 1'b1;
          end
          ACT_POP: begin
            lv_sel = first_lv;
            if (any_held) begin
              lv_d    = first_lv;
              state_d = S_POP_RD;
            end else begin
              st_code = ST_EMPTY;
              finish  = 1'b1;
            end
          end
          ACT_REMOVE: begin
            lv_d    = '0;
            rcnt_d  = '0;
            wcnt_d  = '0;
            sum_d   = '0;
            state_d = S_RM_SCAN;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end

      // read data of the head entry is back; advance head
      S_POP_RD: begin
        slot_off     = FW'(1);
        got          = rd_out;
        head_d[lv_q] = slot_res;
        fill_d[lv_q] = fill_q[lv_q] - 1'b1;
        new_total    = total_q - 1'b1;
        total_d      = new_total;
        finish       = 1'b1;
      end

      // issue read of entry r, or close the level
      S_RM_SCAN: begin
        slot_off = rcnt_q;
        if (rcnt_q == fill_q[lv_q]) begin
          fill_d[lv_q] = wcnt_q;
          sum_d        = sum_q + TW'(wcnt_q);
          rcnt_d       = '0;
          wcnt_d       = '0;
          if (lv_q == LAST_LV) begin
            new_total = sum_q + TW'(wcnt_q);
            total_d   = new_total;
            finish    = 1'b1;
          end else begin
            lv_d = lv_q + 1'b1;
          end
        end else begin
          state_d = S_RM_CHECK;
        end
      end

      // keep entry r at position w unless it matches
      S_RM_CHECK: begin
        slot_off    = wcnt_q;
        mem_wdata_o = mem_rdata_i;
        if (mem_rdata_i != hdl_q) begin
          mem_we_o = 1'b1;
          wcnt_d   = wcnt_q + 1'b1;
        end
        rcnt_d  = rcnt_q + 1'b1;
        state_d = S_RM_SCAN;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // capture the result word
    if (finish) begin
      res_d.popped_handle = got;
      res_d.status        = st_code;
      res_d.total_count   = '0;
      for (int i = 0; i < int'(COUNT_W); i++) begin
        if (i < int'(TW)) begin
          res_d.total_count[i] = new_total[i];
        end
      end
      state_d = S_DONE;
    end
  end

  assign slot_base  = head_q[lv_sel];
  assign mem_addr_o = {lv_sel, slot_res};
  assign res_word_o = res_q;

endmodule
`default_nettype wire

>>> sv/multilevel_priority_task_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multilevel priority task queue
// Per-level FIFOs of task handles with push, pop-most-urgent and remove-all.
// ----------------------------------------------------------------------------
// One word is worked at a time. A word is taken in the idle state, then a
// push or an unused action passes through the execute state, a pop through
// the execute state and a head read state (the entry store has a registered
// read), and a remove through a scan of each level that reads and rewrites
// each held entry through the single-port entry store and the shared slot
// adder. The result is then handed to an output register, and the next word
// is taken while a result waits on the output. A push into a full level is
// dropped with status full; a level above the last one goes to the last
// level.
module multilevel_priority_task_queue #(
  parameter int unsigned LEVELS      = mpq_pkg::LEVELS_DEF,
  parameter int unsigned LEVEL_DEPTH = mpq_pkg::LEVEL_DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = mpq_pkg::HANDLE_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire mpq_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output mpq_pkg::out_word_t      out_word_o
);

  import mpq_pkg::*;

  localparam int unsigned LVW       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned PW        = $clog2(LEVEL_DEPTH);
  localparam int unsigned AW        = LVW + PW;
  localparam int unsigned MEM_DEPTH = LEVELS * (2 ** PW);

  logic                   res_valid;
  logic                   res_take;
  out_word_t              res_word;
  logic                   mem_we;
  logic [AW-1:0]          mem_addr;
  logic [HANDLE_BITS-1:0] mem_wdata;
  logic [HANDLE_BITS-1:0] mem_rdata;
  logic                   out_valid_q;
  out_word_t              out_q;

  mpq_ctrl #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .HANDLE_BITS (HANDLE_BITS),
    .LVW         (LVW),
    .PW          (PW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_word_o  (res_word),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  mpq_store #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW),
    .DW    (HANDLE_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Output register: load when empty or being drained
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire
